// ----- sv/md5_digest_engine_top_assert.svh -----
// Assertion macros for the MD5 digest engine RTL.
`ifndef MD5_DIGEST_ENGINE_TOP_ASSERT_SVH
`define MD5_DIGEST_ENGINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MD5_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MD5_ASSERT_IMPL(lbl, ante, cons, msg)

`define MD5_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/md5_pkg.sv -----
// Shared types, constants and round functions of the MD5 digest engine.
`default_nettype none

package md5_pkg;

  typedef logic [15:0][31:0] md5_block_t;
  typedef logic [3:0][31:0]  md5_chain_t;

  typedef struct packed {
    logic start;
    logic clear;
  } md5_core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md5_core_sts_t;

  localparam int unsigned ROUNDS = 64;
  localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [31:0] CNT_MAX = 32'hffff_ffff;

  localparam md5_chain_t CHAIN_INIT = {32'h1032_5476, 32'h98ba_dcfe,
                                       32'hefcd_ab89, 32'h6745_2301};

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] idx;
    case (rnd[5:4])
      2'd0: idx = rnd[3:0];
      2'd1: idx = 4'(rnd[3:0] * 4'd5 + 4'd1);
      2'd2: idx = 4'(rnd[3:0] * 4'd3 + 4'd5);
      default: idx = 4'(rnd[3:0] * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- sv/md5_core.sv -----
// MD5 block compression: one shared round unit stepped over 64 rounds.
`default_nettype none

module md5_core import md5_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire md5_core_ctrl_t ctrl_i,
  input  wire md5_block_t     block_i,
  output md5_chain_t          chain_o,
  output md5_core_sts_t       status_o
);

  md5_chain_t  chain_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  rnd_q;
  logic        run_q, fold_q;

  logic [31:0] fn, sum, rot;
  logic [63:0] dbl;
  logic [4:0]  amt;

  always_comb begin
    fn  = round_fn(rnd_q[5:4], b_q, c_q, d_q);
    sum = a_q + fn + ROUND_K[rnd_q] + block_i[msg_index(rnd_q)];
    amt = ROT_AMT[{rnd_q[5:4], rnd_q[1:0]}];
    dbl = {sum, sum} << amt;
    rot = dbl[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= CHAIN_INIT;
      rnd_q   <= '0;
      run_q   <= 1'b0;
      fold_q  <= 1'b0;
    end else begin
      fold_q <= 1'b0;
      if (ctrl_i.clear) begin
        chain_q <= CHAIN_INIT;
      end else if (fold_q) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end
      if (ctrl_i.start && !run_q && !fold_q) begin
        rnd_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          run_q  <= 1'b0;
          fold_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !run_q && !fold_q) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (run_q) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  assign chain_o         = chain_q;
  assign status_o.busy   = run_q | fold_q;
  assign status_o.done   = fold_q;

endmodule

`default_nettype wire

// ----- sv/md5_digest_engine_top.sv -----
// MD5 digest engine top level: byte packing, padding sequencer and result register.
//
// Usage: stream a message one byte per transfer on the input channel
// (data_byte_i, has_byte_i, last_i). A transfer with has_byte_i low and
// last_i low does nothing; has_byte_i low with last_i high ends the
// message without a byte (an empty message is that single transfer).
// After last_i the block pads the message and presents one result on the
// output channel: the 128-bit digest, byte 0 in digest_low_o[7:0], and
// length_overflow_o if more than 2^32-1 bytes were given.
// Flow: a byte that does not fill a block leaves the input ready; a byte
// that fills a block starts a compression (64 rounds through the shared
// round unit plus one chaining add), and ready returns when it ends.
// After last, padding writes one byte per cycle up to offset 56 and the
// length is written; one or two compressions run, as the padding may fill
// a block on the way, and the digest then moves to the output register
// once that register is free. The input is not ready while a block is
// compressed or a finished digest waits for a busy output
// register. A stalled receiver holds the result there while the next
// message streams in. Reset restores the MD5 initial chaining words and
// clears the byte count, block position, overflow flag and output register.
`default_nettype none

module md5_digest_engine_top import md5_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      digest_low_o,
  output logic [63:0]      digest_high_o,
  output logic             length_overflow_o
);

`include "md5_digest_engine_top_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_PAD   = 5'b00100,
    ST_LEN   = 5'b01000,
    ST_OUT   = 5'b10000
  } md5_state_e;

  md5_state_e     state_q, state_d;
  logic [31:0]    msg_cnt_q, msg_cnt_d;
  logic [5:0]     pos_q, pos_d, pos_inc;
  logic           ovf_q, ovf_d;
  logic           fin_q, fin_d;
  logic           final_q, final_d;
  logic           pad_first_q, pad_first_d;
  logic           out_valid_q, out_valid_d;
  logic [63:0]    out_low_q, out_low_d;
  logic [63:0]    out_high_q, out_high_d;
  logic           out_ovf_q, out_ovf_d;
  logic           out_load;
  md5_block_t     block_q;
  logic           put_en, len_wr;
  logic [7:0]     put_byte;
  md5_core_ctrl_t core_ctrl;
  md5_core_sts_t  core_sts;
  md5_chain_t     chain;

  assign pos_inc = pos_q + 6'd1;

  always_comb begin
    state_d     = state_q;
    msg_cnt_d   = msg_cnt_q;
    ovf_d       = ovf_q;
    fin_d       = fin_q;
    final_d     = final_q;
    pad_first_d = pad_first_q;
    out_valid_d = out_valid_q;
    out_low_d   = out_low_q;
    out_high_d  = out_high_q;
    out_ovf_d   = out_ovf_q;
    out_load    = 1'b0;
    put_en      = 1'b0;
    put_byte    = '0;
    len_wr      = 1'b0;
    core_ctrl   = '0;
    pos_d       = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pad_first_d = 1'b1;
          fin_d       = last_i;
          if (has_byte_i) begin
            if (msg_cnt_q == CNT_MAX) begin
              ovf_d = 1'b1;
            end else begin
              msg_cnt_d = msg_cnt_q + 32'd1;
            end
            put_en   = 1'b1;
            put_byte = data_byte_i;
            if (pos_inc == '0) begin
              core_ctrl.start = 1'b1;
              state_d         = ST_ROUND;
            end else if (last_i) begin
              state_d = ST_PAD;
            end
          end else if (last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (core_sts.done) begin
          if (final_q) begin
            state_d = ST_OUT;
          end else if (fin_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        put_en      = 1'b1;
        put_byte    = pad_first_q ? PAD_BYTE : 8'h00;
        pad_first_d = 1'b0;
        if (pos_inc == '0) begin
          core_ctrl.start = 1'b1;
          state_d         = ST_ROUND;
        end else if (pos_inc == LEN_POS) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        len_wr          = 1'b1;
        core_ctrl.start = 1'b1;
        final_d         = 1'b1;
        pos_d           = '0;
        state_d         = ST_ROUND;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load        = 1'b1;
          core_ctrl.clear = 1'b1;
          msg_cnt_d       = '0;
          ovf_d           = 1'b0;
          fin_d           = 1'b0;
          final_d         = 1'b0;
          pos_d           = '0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (put_en) begin
      pos_d = pos_inc;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_low_d   = {chain[1], chain[0]};
      out_high_d  = {chain[3], chain[2]};
      out_ovf_d   = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      msg_cnt_q   <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      fin_q       <= 1'b0;
      final_q     <= 1'b0;
      pad_first_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_low_q   <= '0;
      out_high_q  <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      msg_cnt_q   <= msg_cnt_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      fin_q       <= fin_d;
      final_q     <= final_d;
      pad_first_q <= pad_first_d;
      out_valid_q <= out_valid_d;
      out_low_q   <= out_low_d;
      out_high_q  <= out_high_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put_en) begin
      if (pos_q[1:0] == 2'd0) begin
        block_q[pos_q[5:2]] <= {24'h000000, put_byte};
      end else begin
        block_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= put_byte;
      end
    end
    if (len_wr) begin
      block_q[14] <= {msg_cnt_q[28:0], 3'b000};
      block_q[15] <= {29'h0, msg_cnt_q[31:29]};
    end
  end

  md5_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (core_ctrl),
    .block_i  (block_q),
    .chain_o  (chain),
    .status_o (core_sts)
  );

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign digest_low_o      = out_low_q;
  assign digest_high_o     = out_high_q;
  assign length_overflow_o = out_ovf_q;

  `MD5_ASSERT_IMPL(a_idle_core_quiet, state_q == ST_IDLE, !core_sts.busy, "input ready while core busy")
  `MD5_ASSERT_IMPL(a_done_in_round, core_sts.done, state_q == ST_ROUND, "core done outside round state")
  `MD5_ASSERT_IMPL(a_out_settled, state_q == ST_OUT, (pos_q == '0) && !core_sts.busy, "digest pending before block done")
  `MD5_ASSERT_NEXT(a_len_starts_core, state_q == ST_LEN, core_sts.busy && final_q, "length block not compressed")
  `MD5_ASSERT_NEXT(a_out_clears, out_load, (msg_cnt_q == '0) && !ovf_q && in_ready_o && out_valid_o, "state not cleared after result")
  `MD5_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(digest_low_o), "result dropped while stalled")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for md5_digest_engine_top: streamed messages checked against an MD5 model.
module testbench;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        ovf;
  } digest_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
    logic       typed;
    digest_t    want;
  } stim_row_t;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 1835;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LENGTH_SLOT = 6'd56;
  localparam logic [31:0] COUNT_FULL = 32'hffff_ffff;

  localparam logic [0:3][31:0] IV_WORDS = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [0:63][31:0] SINE_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [0:15][4:0] SHIFT_BY = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam digest_t MD5_EMPTY = '{64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9, 1'b0};
  localparam digest_t MD5_A     = '{64'ha8b6f1c0b975c10c, 64'h61267769e299c331, 1'b0};
  localparam digest_t MD5_ABC   = '{64'hb04fd23c98500190, 64'h727fe1287d3f96d6, 1'b0};
  localparam digest_t NO_DIGEST = '{64'h0, 64'h0, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        last = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [63:0] digest_low;
  logic [63:0] digest_high;
  logic        length_overflow;

  logic [31:0] hash_state [4];
  logic [31:0] block_buf [16];
  logic [31:0] byte_count;
  logic [5:0]  fill;
  logic        count_saturated;

  digest_t     digests_due [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        steady = 1'b0;

  stim_row_t directed_rows [15] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, MD5_EMPTY},
    '{8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{8'h61, 1'b1, 1'b1, 1'b1, MD5_A},
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b1, 1'b1, MD5_ABC},
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hff, 1'b0, 1'b1, 1'b0, NO_DIGEST},
    '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'ha5, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b1, MD5_EMPTY}
  };

  md5_digest_engine_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (byte_valid),
    .in_ready_o        (byte_ready),
    .data_byte_i       (data_byte),
    .has_byte_i        (has_byte),
    .last_i            (last),
    .out_valid_o       (digest_valid),
    .out_ready_i       (digest_ready),
    .digest_low_o      (digest_low),
    .digest_high_o     (digest_high),
    .length_overflow_o (length_overflow)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void clear_message();
    int k;
    for (k = 0; k < 4; k++) hash_state[k] = IV_WORDS[k];
    for (k = 0; k < 16; k++) block_buf[k] = '0;
    byte_count = '0;
    fill = '0;
    count_saturated = 1'b0;
  endfunction

  function automatic void compress_block_words();
    logic [31:0] a, b, c, d, f, t, sum;
    int i, g, s;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sum = a + f + SINE_K[i] + block_buf[g];
      s = SHIFT_BY[(i / 16) * 4 + i % 4];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    hash_state[0] = hash_state[0] + a;
    hash_state[1] = hash_state[1] + b;
    hash_state[2] = hash_state[2] + c;
    hash_state[3] = hash_state[3] + d;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    if (fill[1:0] == 2'd0) block_buf[fill[5:2]] = {24'h0, v};
    else block_buf[fill[5:2]] = block_buf[fill[5:2]] | ({24'h0, v} << (8 * fill[1:0]));
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block_words();
  endfunction

  function automatic logic hash_transfer(input logic [7:0] d, input logic h, input logic fin,
                                         output digest_t res);
    logic [63:0] nbits;
    res = NO_DIGEST;
    if (h) begin
      if (byte_count == COUNT_FULL) count_saturated = 1'b1;
      else byte_count = byte_count + 32'd1;
      absorb_byte(d);
    end
    if (!fin) return 1'b0;
    nbits = {29'h0, byte_count, 3'b000};
    absorb_byte(PAD_MARK);
    while (fill != LENGTH_SLOT) absorb_byte(8'h00);
    block_buf[14] = nbits[31:0];
    block_buf[15] = nbits[63:32];
    compress_block_words();
    res.lo = {hash_state[1], hash_state[0]};
    res.hi = {hash_state[3], hash_state[2]};
    res.ovf = count_saturated;
    clear_message();
    return 1'b1;
  endfunction

  function automatic int draw_pause();
    if (steady || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic h, input logic fin,
                           input logic typed, input digest_t want);
    int pause;
    digest_t got;
    pause = draw_pause();
    if (pause > 0) begin
      byte_valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    byte_valid <= 1'b1;
    data_byte <= d;
    has_byte <= h;
    last <= fin;
    do @(posedge clk_i); while (!byte_ready);
    if (hash_transfer(d, h, fin, got)) digests_due.push_back(typed ? want : got);
  endtask

  task automatic drain_digests();
    byte_valid <= 1'b0;
    @(posedge clk_i);
    while (digests_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    digest_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_pause();
      if (stall > 0) begin
        digest_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      digest_ready <= 1'b1;
      do @(posedge clk_i); while (digest_valid !== 1'b1);
      if (digests_due.size() == 0) begin
        $error("digest transfer with none expected: low %h high %h", digest_low, digest_high);
        errors++;
      end else begin
        want = digests_due.pop_front();
        if (digest_low !== want.lo) begin
          $error("digest_low expected %h actual %h", want.lo, digest_low);
          errors++;
        end
        if (digest_high !== want.hi) begin
          $error("digest_high expected %h actual %h", want.hi, digest_high);
          errors++;
        end
        if (length_overflow !== want.ovf) begin
          $error("length_overflow expected %b actual %b", want.ovf, length_overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    int k, n, pick, sent;
    logic bare_end;
    clear_message();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].data, directed_rows[r].has, directed_rows[r].fin,
                directed_rows[r].typed, directed_rows[r].want);
    end
    drain_digests();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) n = $urandom_range(0, 20);
      else if (pick < 8) n = $urandom_range(50, 72);
      else if (pick < 9) n = $urandom_range(110, 135);
      else n = $urandom_range(0, 300);
      bare_end = (n == 0) || ($urandom_range(0, 3) == 0);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
          sent++;
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1, (k == n - 1) && !bare_end,
                  1'b0, NO_DIGEST);
        sent++;
      end
      if (bare_end) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) drain_digests();
    end
    steady = 1'b0;
    byte_valid <= 1'b0;

    while (digests_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
